>>> src/alu8_pkg.sv
// types, operation codes and the flag evaluation function for the 8-bit alu
package alu8_pkg;

    localparam int DATA_W = 8;

    localparam logic [3:0] FN_MOV  = 4'd0;
    localparam logic [3:0] FN_INC  = 4'd1;
    localparam logic [3:0] FN_INCC = 4'd2;
    localparam logic [3:0] FN_DEC  = 4'd3;
    localparam logic [3:0] FN_DECC = 4'd4;
    localparam logic [3:0] FN_ADD  = 4'd5;
    localparam logic [3:0] FN_ADC  = 4'd6;
    localparam logic [3:0] FN_SUB  = 4'd7;
    localparam logic [3:0] FN_SBC  = 4'd8;
    localparam logic [3:0] FN_AND  = 4'd9;
    localparam logic [3:0] FN_OR   = 4'd10;
    localparam logic [3:0] FN_XOR  = 4'd11;
    localparam logic [3:0] FN_RR   = 4'd12;
    localparam logic [3:0] FN_RL   = 4'd13;
    localparam logic [3:0] FN_RRC  = 4'd14;
    localparam logic [3:0] FN_RLC  = 4'd15;

    typedef struct packed {
        logic              carry_in;
        logic [DATA_W-1:0] operand;
        logic [DATA_W-1:0] acc;
        logic [3:0]        func;
    } alu_in_t;

    typedef struct packed {
        logic              carry_flag;
        logic              subtract_flag;
        logic              parity_overflow;
        logic              half_flag;
        logic              zero_flag;
        logic              sign_flag;
        logic [DATA_W-1:0] result;
    } alu_out_t;

    function automatic alu_out_t alu_eval(input alu_in_t op);
        alu_out_t          r;
        logic [DATA_W:0]   wide;
        logic [DATA_W-1:0] d;
        logic [DATA_W:0]   a9;
        logic [DATA_W:0]   b9;
        logic [DATA_W:0]   c9;
        logic              c;
        logic              n;
        logic              pv;
        logic              sa;
        logic              sb;
        logic              sd;
        a9   = {1'b0, op.acc};
        b9   = {1'b0, op.operand};
        c9   = {{DATA_W{1'b0}}, op.carry_in};
        wide = '0;
        d    = '0;
        c    = 1'b0;
        n    = 1'b0;
        sa   = op.acc[DATA_W-1];
        sb   = op.operand[DATA_W-1];
        case (op.func)
            FN_INC:  wide = b9 + {{DATA_W{1'b0}}, 1'b1};
            FN_INCC: wide = b9 + c9;
            FN_DEC:  wide = b9 - {{DATA_W{1'b0}}, 1'b1};
            FN_DECC: wide = b9 - c9;
            FN_ADD:  wide = a9 + b9;
            FN_ADC:  wide = a9 + b9 + c9;
            FN_SUB:  wide = a9 - b9;
            FN_SBC:  wide = a9 - b9 - c9;
            default: wide = '0;
        endcase
        sd = wide[DATA_W-1];
        pv = 1'b0;
        case (op.func)
            FN_MOV:  d = op.operand;
            FN_INC, FN_INCC: begin
                d  = wide[DATA_W-1:0];
                c  = wide[DATA_W];
                pv = sb ^ sd;
            end
            FN_DEC, FN_DECC: begin
                d  = wide[DATA_W-1:0];
                c  = wide[DATA_W];
                n  = 1'b1;
                pv = sb ^ sd;
            end
            FN_ADD, FN_ADC: begin
                d  = wide[DATA_W-1:0];
                c  = wide[DATA_W];
                pv = ~(sa ^ sb) & (sa ^ sd);
            end
            FN_SUB, FN_SBC: begin
                d  = wide[DATA_W-1:0];
                c  = wide[DATA_W];
                n  = 1'b1;
                pv = (sa ^ sb) & (sa ^ sd);
            end
            FN_AND:  d = op.acc & op.operand;
            FN_OR:   d = op.acc | op.operand;
            FN_XOR:  d = op.acc ^ op.operand;
            FN_RR: begin
                d = {op.carry_in, op.operand[DATA_W-1:1]};
                c = op.operand[0];
            end
            FN_RL: begin
                d = {op.operand[DATA_W-2:0], op.carry_in};
                c = op.operand[DATA_W-1];
            end
            FN_RRC: begin
                d = {op.operand[0], op.operand[DATA_W-1:1]};
                c = op.operand[0];
            end
            default: begin
                d = {op.operand[DATA_W-2:0], op.operand[DATA_W-1]};
                c = op.operand[DATA_W-1];
            end
        endcase
        // logic, move and rotates report even parity instead of overflow
        case (op.func)
            FN_INC, FN_INCC, FN_DEC, FN_DECC,
            FN_ADD, FN_ADC, FN_SUB, FN_SBC: r.parity_overflow = pv;
            default:                        r.parity_overflow = ~(^d);
        endcase
        r.result        = d;
        r.sign_flag     = d[DATA_W-1];
        r.zero_flag     = (d == '0);
        r.half_flag     = 1'b0;
        r.subtract_flag = n;
        r.carry_flag    = c;
        return r;
    endfunction

endpackage

>>> src/alu_8bit_with_flags.sv
// 8-bit alu with z80 style flags, input register and result register
//
// input channel s_axis_*: one operation per transfer (function code,
// accumulator, operand, carry in). result channel m_axis_*: one result byte
// with its six flags per transfer, in the order the operations came in.
// the operation is captured in an input register, evaluated by one level of
// combinational add/logic/rotate logic, and the result lands in the output
// register. throughput is one operation per cycle while m_axis_tready is high;
// each of the two register stages advances whenever the one after it is empty
// or being drained.
// when the receiver holds m_axis_tready low the output register holds its
// result stable, the input register fills, and s_axis_tready drops after at
// most one more transfer; nothing is lost or repeated.
// reset (aresetn low at a clock edge) empties both stages; the data registers
// need no reset, so the first operation after reset is handled like any other.
module alu_8bit_with_flags (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[3:0], acc[11:4], operand[19:12], carry_in[20], zero fill [23:21]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[7:0], sign_flag[8], zero_flag[9], half_flag[10],
    // parity_overflow[11], subtract_flag[12], carry_flag[13], zero fill [15:14]
    output logic [15:0] m_axis_tdata
);
    import alu8_pkg::*;

    logic     in_valid_reg;
    logic     out_valid_reg;
    alu_in_t  in_data_reg;
    alu_out_t out_data_reg;
    alu_out_t out_data_next;
    logic     out_load;
    logic     in_load;

    assign out_load      = ~out_valid_reg | m_axis_tready;
    assign in_load       = ~in_valid_reg | out_load;
    assign s_axis_tready = in_load;

    assign out_data_next = alu_eval(in_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_axis_tvalid) begin
            in_data_reg <= alu_in_t'(s_axis_tdata[$bits(alu_in_t)-1:0]);
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - $bits(alu_out_t)){1'b0}}, out_data_reg};

endmodule
